FILE: design/fixed_point_q24_8_alu_macros.svh
// Assertion helpers for the Q24.8 ALU
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH

// Check a property on every clock edge outside reset
`define FQA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset
`define FQA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: design/fqa_pkg.sv
package fqa_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 8;
  localparam int unsigned CmdBits  = 4;
  localparam int unsigned ErrBits  = 2;

  // Dividend and radicand width: operand shifted left by the fraction bits
  localparam int unsigned WideBits = WordBits + FracBits;
  localparam int unsigned CntBits  = $clog2(WideBits + 1);

  localparam logic [CmdBits-1:0] CmdAdd  = 4'd0;
  localparam logic [CmdBits-1:0] CmdSub  = 4'd1;
  localparam logic [CmdBits-1:0] CmdMul  = 4'd2;
  localparam logic [CmdBits-1:0] CmdDiv  = 4'd3;
  localparam logic [CmdBits-1:0] CmdSqrt = 4'd4;
  localparam logic [CmdBits-1:0] CmdMin  = 4'd5;
  localparam logic [CmdBits-1:0] CmdMax  = 4'd6;
  localparam logic [CmdBits-1:0] CmdCmp  = 4'd7;
  localparam logic [CmdBits-1:0] CmdInc  = 4'd8;
  localparam logic [CmdBits-1:0] CmdDec  = 4'd9;
  localparam logic [CmdBits-1:0] CmdToInt   = 4'd10;
  localparam logic [CmdBits-1:0] CmdFromInt = 4'd11;

  localparam logic [ErrBits-1:0] ErrNone = 2'd0;
  localparam logic [ErrBits-1:0] ErrDivZero = 2'd1;
  localparam logic [ErrBits-1:0] ErrSqrtNeg = 2'd2;

endpackage

FILE: design/fixed_point_q24_8_alu.sv
// Signed Q24.8 arithmetic unit.
// Command channel: drive command_i, operand_a_i, operand_b_i and raise start_i;
// the item is taken at a rising edge where start_i is high and busy_o is low.
// Result channel: valid_o is high for exactly one cycle with result_value_o,
// the compare flags and error_code_o; the receiver cannot stall it.
// Pipeline: stage 1 registers the operands and decodes, held while the shared
// shift-subtract unit runs divide or square root; stage 2 holds the multiplier
// product or recurrence answer; stage 3 forms the answer; the output register presents it.
// Add, sub, mul, min, max, compare, inc, dec and conversions pass through
// the stages in turn, and a new item may enter every cycle while busy_o is low.
// Divide and square root wait in stage 1 for the recurrence unit, which
// resolves one quotient bit (or one root bit) per cycle; busy_o is high
// while it runs, holding stage 1 and blocking the command channel until
// the answer moves on.
// Reset clears all valid bits and the recurrence run, done and count registers; payload is not reset.
`include "fixed_point_q24_8_alu_macros.svh"

module fixed_point_q24_8_alu (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [fqa_pkg::CmdBits-1:0]        command_i,
  input  logic signed [fqa_pkg::WordBits-1:0] operand_a_i,
  input  logic signed [fqa_pkg::WordBits-1:0] operand_b_i,
  output logic                               valid_o,
  output logic signed [fqa_pkg::WordBits-1:0] result_value_o,
  output logic                               is_less_o,
  output logic                               is_equal_o,
  output logic                               is_greater_o,
  output logic [fqa_pkg::ErrBits-1:0]        error_code_o
);

  localparam int unsigned W  = fqa_pkg::WordBits;
  localparam int unsigned F  = fqa_pkg::FracBits;
  localparam int unsigned WB = fqa_pkg::WideBits;
  localparam int unsigned CB = fqa_pkg::CntBits;

  typedef struct packed {
    logic [fqa_pkg::CmdBits-1:0] cmd;
    logic signed [W-1:0]         a;
    logic signed [W-1:0]         b;
  } item_t;

  // Stage 1: capture item
  logic  s1_vld_q;
  item_t s1_q;
  logic  iter_run_q;
  logic  s1_iter, s1_go;
  logic  iter_done_w;

  assign s1_iter = s1_vld_q && (s1_q.cmd == fqa_pkg::CmdDiv || s1_q.cmd == fqa_pkg::CmdSqrt);
  // stage 1 moves on unless its recurrence has not finished yet
  assign s1_go   = s1_vld_q && !iter_run_q && (!s1_iter || iter_done_w);
  assign busy_o  = s1_vld_q && !s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (!busy_o) begin
      s1_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      s1_q <= '{cmd: command_i, a: operand_a_i, b: operand_b_i};
    end
  end

  // Recurrence unit: restoring divide or bit-pair square root
  logic [WB-1:0]   num_q;    // dividend magnitude or radicand, shifted out high first
  logic [W-1:0]    den_q;    // divisor magnitude
  logic [WB:0]     rem_q;    // partial remainder
  logic [WB-1:0]   quo_q;    // quotient or root bits
  logic [CB-1:0]   cnt_q;
  logic            is_sqrt_q;
  logic            neg_q;
  logic            done_q;   // result of last run is ready for stage 2

  logic [WB:0]     trial;
  logic [WB:0]     rem_sh;
  logic [WB-1:0]   a_wide, a_mag;
  logic [W-1:0]    b_mag;

  assign iter_done_w = done_q;
  assign a_wide = {{F{s1_q.a[W-1]}}, s1_q.a} <<< F;
  assign a_mag  = s1_q.a[W-1] ? (~a_wide + 1'b1) : a_wide;
  assign b_mag  = s1_q.b[W-1] ? (~s1_q.b + 1'b1) : s1_q.b;

  always_comb begin
    if (is_sqrt_q) begin
      rem_sh = {rem_q[WB-2:0], num_q[WB-1 -: 2]};
      trial  = rem_sh - {quo_q[WB-3:0], 2'b01};
    end else begin
      rem_sh = {rem_q[WB-1:0], num_q[WB-1]};
      trial  = rem_sh - {{(WB+1-W){1'b0}}, den_q};
    end
  end

  logic iter_start;
  assign iter_start = s1_iter && !iter_run_q && !done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_run_q <= 1'b0;
      done_q     <= 1'b0;
      cnt_q      <= '0;
    end else if (iter_start) begin
      iter_run_q <= 1'b1;
      cnt_q      <= (s1_q.cmd == fqa_pkg::CmdSqrt) ? CB'(WB / 2) : CB'(WB);
    end else if (iter_run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CB'(1)) begin
        iter_run_q <= 1'b0;
        done_q     <= 1'b1;
      end
    end else if (done_q) begin
      done_q <= 1'b0;
    end
  end

  // Step the recurrence one result bit per cycle
  always_ff @(posedge clk_i) begin
    if (iter_start) begin
      is_sqrt_q <= (s1_q.cmd == fqa_pkg::CmdSqrt);
      num_q     <= (s1_q.cmd == fqa_pkg::CmdSqrt) ? a_wide : a_mag;
      den_q     <= b_mag;
      neg_q     <= s1_q.a[W-1] ^ s1_q.b[W-1];
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (iter_run_q) begin
      if (is_sqrt_q) begin
        num_q <= num_q << 2;
      end else begin
        num_q <= num_q << 1;
      end
      if (!trial[WB]) begin
        rem_q <= trial;
        quo_q <= {quo_q[WB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[WB-2:0], 1'b0};
      end
    end
  end

  // Stage 2: product, compares, recurrence answer
  logic                s2_vld_q;
  item_t               s2_q;
  logic signed [2*W-1:0] prod_q;
  logic [W-1:0]        quo_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_q    <= s1_q;
      prod_q  <= s1_q.a * s1_q.b;
      quo_w_q <= (neg_q && !is_sqrt_q) ? W'(~quo_q + 1'b1) : quo_q[W-1:0];
    end
  end

  // Stage 3: select the answer
  logic                s3_vld_q;
  logic signed [W-1:0] res_d, res_q;
  logic [fqa_pkg::ErrBits-1:0] err_d, err_q;
  logic                lt_q, eq_q, gt_q;
  logic                lt_w;

  assign lt_w = s2_q.a < s2_q.b;

  always_comb begin
    res_d = '0;
    err_d = fqa_pkg::ErrNone;
    case (s2_q.cmd)
      fqa_pkg::CmdAdd: res_d = s2_q.a + s2_q.b;
      fqa_pkg::CmdSub: res_d = s2_q.a - s2_q.b;
      fqa_pkg::CmdMul: res_d = prod_q[F +: W];
      fqa_pkg::CmdDiv: begin
        if (s2_q.b == '0) begin
          err_d = fqa_pkg::ErrDivZero;
        end else begin
          res_d = quo_w_q;
        end
      end
      fqa_pkg::CmdSqrt: begin
        if (s2_q.a[W-1]) begin
          err_d = fqa_pkg::ErrSqrtNeg;
        end else begin
          res_d = quo_w_q;
        end
      end
      fqa_pkg::CmdMin: res_d = lt_w ? s2_q.a : s2_q.b;
      fqa_pkg::CmdMax: res_d = lt_w ? s2_q.b : s2_q.a;
      fqa_pkg::CmdInc: res_d = s2_q.a + 1'b1;
      fqa_pkg::CmdDec: res_d = s2_q.a - 1'b1;
      fqa_pkg::CmdToInt: res_d = s2_q.a >>> F;
      fqa_pkg::CmdFromInt: res_d = s2_q.a <<< F;
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      res_q <= res_d;
      err_q <= err_d;
      lt_q  <= lt_w;
      eq_q  <= s2_q.a == s2_q.b;
      gt_q  <= s2_q.a > s2_q.b;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      result_value_o <= res_q;
      error_code_o   <= err_q;
      is_less_o      <= lt_q;
      is_equal_o     <= eq_q;
      is_greater_o   <= gt_q;
    end
  end

  `FQA_ASSERT(a_flags_onehot, !valid_o || $onehot({is_less_o, is_equal_o, is_greater_o}),
              "compare flags not one-hot")
  `FQA_ASSERT_IMP(a_busy_iter, iter_run_q, busy_o, "recurrence running but not busy")
  `FQA_ASSERT_IMP(a_run_done, done_q, !iter_run_q, "recurrence done while running")

endmodule
